### rtl/mrrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrrf_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one classified request item, front to back
    typedef struct packed {
        logic        is_write;
        logic        first;
        logic        last;
        logic [15:0] start_address;
        logic [6:0]  word_count;
        logic [15:0] word_value;
    } t_desc;

    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_qwr;

endpackage

`default_nettype wire

### rtl/mrrf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mrrf_front
    import mrrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_start_address,
    input  wire logic [6:0]  i_word_count,
    input  wire logic [15:0] i_word_value,
    input  wire logic        i_first_word,
    input  wire logic        i_last_word,
    input  wire logic        i_q_full,
    output t_qwr             o_qwr
);

    localparam logic CMD_READ = 1'b0;

    logic r_open;
    logic n_open;
    logic accept;
    logic keep;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;
    // a word with no open frame and no header is dropped
    assign keep   = (i_cmd == CMD_READ) || i_first_word || r_open;

    always_comb begin
        o_qwr.push               = accept && keep;
        o_qwr.desc.is_write      = (i_cmd != CMD_READ);
        o_qwr.desc.first         = i_first_word;
        o_qwr.desc.last          = i_last_word;
        o_qwr.desc.start_address = i_start_address;
        o_qwr.desc.word_count    = i_word_count;
        o_qwr.desc.word_value    = i_word_value;
    end

    always_comb begin
        n_open = r_open;
        if (accept) begin
            if (i_cmd == CMD_READ) begin
                n_open = 1'b0;
            end else if (keep) begin
                n_open = !i_last_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

endmodule

`default_nettype wire

### rtl/mrrf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mrrf_queue
    import mrrf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qwr  i_qwr,
    output logic       o_full,
    output logic       o_empty,
    output t_desc      o_head,
    input  wire logic  i_pop
);

    t_desc          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign wr_en   = i_qwr.push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_qwr.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= QAW'(r_wr + 1'b1);
            end
            if (rd_en) begin
                r_rd <= QAW'(r_rd + 1'b1);
            end
            r_count <= (QAW+1)'(r_count + {{QAW{1'b0}}, wr_en} - {{QAW{1'b0}}, rd_en});
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor queue popped while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == (QAW+1)'($past(r_count) + {{QAW{1'b0}}, $past(wr_en)}
                                      - {{QAW{1'b0}}, $past(rd_en)}))
        else $error("descriptor queue count out of step");
`endif

endmodule

`default_nettype wire

### rtl/mrrf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mrrf_back
    import mrrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire t_desc       i_head,
    input  wire logic        i_q_empty,
    output logic             o_q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte
);

    localparam logic       REG_SERVER_ADDRESS = 1'b0;
    localparam logic       REG_CRC_LOW_FIRST  = 1'b1;
    localparam logic [7:0] FN_READ            = 8'h03;
    localparam logic [7:0] FN_WRITE           = 8'h10;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    localparam logic [3:0] STEP_ADDR     = 4'd0;
    localparam logic [3:0] STEP_FUNC     = 4'd1;
    localparam logic [3:0] STEP_SA_HI    = 4'd2;
    localparam logic [3:0] STEP_SA_LO    = 4'd3;
    localparam logic [3:0] STEP_CNT_HI   = 4'd4;
    localparam logic [3:0] STEP_CNT_LO   = 4'd5;
    localparam logic [3:0] STEP_BYTE_CNT = 4'd6;
    localparam logic [3:0] STEP_VAL_HI   = 4'd7;
    localparam logic [3:0] STEP_VAL_LO   = 4'd8;
    localparam logic [3:0] STEP_CRC_A    = 4'd9;
    localparam logic [3:0] STEP_CRC_B    = 4'd10;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [7:0]  r_server_address;
    logic        r_crc_low_first;
    logic [15:0] r_crc;
    logic        r_busy;
    logic [3:0]  r_step;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic [3:0]  start_step;
    logic [3:0]  cur;
    logic [3:0]  nxt;
    logic        final_step;
    logic [7:0]  cur_byte;
    logic [15:0] crc_base;
    logic        advance;

    assign start_step = (i_head.is_write && !i_head.first) ? STEP_VAL_HI : STEP_ADDR;
    assign cur        = r_busy ? r_step : start_step;
    assign crc_base   = (cur == STEP_ADDR) ? CRC_INIT : r_crc;
    assign advance    = !i_q_empty && (!r_out_valid || pop);
    assign o_q_pop    = advance && final_step;

    always_comb begin
        case (cur)
            STEP_ADDR:     cur_byte = r_server_address;
            STEP_FUNC:     cur_byte = i_head.is_write ? FN_WRITE : FN_READ;
            STEP_SA_HI:    cur_byte = i_head.start_address[15:8];
            STEP_SA_LO:    cur_byte = i_head.start_address[7:0];
            STEP_CNT_HI:   cur_byte = 8'h00;
            STEP_CNT_LO:   cur_byte = {1'b0, i_head.word_count};
            STEP_BYTE_CNT: cur_byte = {i_head.word_count, 1'b0};
            STEP_VAL_HI:   cur_byte = i_head.word_value[15:8];
            STEP_VAL_LO:   cur_byte = i_head.word_value[7:0];
            STEP_CRC_A:    cur_byte = r_crc_low_first ? r_crc[7:0] : r_crc[15:8];
            STEP_CRC_B:    cur_byte = r_crc_low_first ? r_crc[15:8] : r_crc[7:0];
            default:       cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        nxt        = 4'(cur + 4'd1);
        final_step = 1'b0;
        case (cur)
            STEP_CNT_LO: begin
                nxt = i_head.is_write ? STEP_BYTE_CNT : STEP_CRC_A;
            end
            STEP_VAL_LO: begin
                nxt        = STEP_CRC_A;
                final_step = !i_head.last;
            end
            STEP_CRC_B: begin
                nxt        = STEP_ADDR;
                final_step = 1'b1;
            end
            default: begin
                nxt = 4'(cur + 4'd1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_address <= 8'd1;
            r_crc_low_first  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SERVER_ADDRESS: r_server_address <= i_cfg_data;
                REG_CRC_LOW_FIRST:  r_crc_low_first  <= i_cfg_data[0];
                default:            r_crc_low_first  <= r_crc_low_first;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_busy      <= 1'b0;
            r_step      <= STEP_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_busy      <= !final_step;
                r_step      <= nxt;
                if (cur != STEP_CRC_A && cur != STEP_CRC_B) begin
                    r_crc <= crc_feed(crc_base, cur_byte);
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= (cur == STEP_CRC_B);
        end
    end

    assign empty        = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

`ifndef SYNTH
    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_q_empty)
        else $error("frame sequencer running without a queued request");

    a_last_after_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (cur == STEP_CRC_B) |=> o_last_byte && !empty)
        else $error("final crc byte not flagged as last");
`endif

endmodule

`default_nettype wire

### rtl/modbus_rtu_request_framer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU request framer: turns request items into a byte stream with CRC-16/Modbus.
// Input channel: push/full. A read item (cmd 0) gives a full eight-byte frame; a write
// frame is a run of word items, the first emitting the seven-byte header, each word two
// bytes, and the last word the two CRC bytes (last_byte set on the final one).
// Words with no open frame and no first_word flag are taken and dropped.
// Output channel: empty/pop; the byte on o_frame_byte is valid while empty is low.
// Config: i_cfg_we/i_cfg_index/i_cfg_data; index 0 server address, index 1 crc order.
// An accepted item is first written into the request queue; its first byte is then registered for output.
// Throughput: one byte per cycle from the frame sequencer while the receiver keeps popping, so a
// read gives 8 bytes, a middle write word 2, a first word 9 and a combined first/last word 11.
// A four-entry request queue sits between the classifier and the sequencer, so the
// input keeps taking items while the output is stalled until that queue fills.
// When pop is held low the current byte holds and the sequencer waits.
// Reset: queue and output cleared, no frame open, server address 1, crc high byte first.

module modbus_rtu_request_framer_top
    import mrrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_start_address,
    input  wire logic [6:0]  i_word_count,
    input  wire logic [15:0] i_word_value,
    input  wire logic        i_first_word,
    input  wire logic        i_last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    t_qwr  qwr;
    t_desc head;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    mrrf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_start_address (i_start_address),
        .i_word_count    (i_word_count),
        .i_word_value    (i_word_value),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_q_full        (q_full),
        .o_qwr           (qwr)
    );

    mrrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    mrrf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

`default_nettype wire

### sim/modbus_frame_checker.sv
`timescale 1ns / 1ps

package mrrf_tb_pkg;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic REG_SERVER_ADDR = 1'b0;
    localparam logic REG_CRC_ORDER   = 1'b1;

endpackage

module modbus_frame_checker
    import mrrf_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_cmd,
    input  logic [15:0] i_start_address,
    input  logic [6:0]  i_word_count,
    input  logic [15:0] i_word_value,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'hA001;
    localparam logic [7:0]  FN_READ_HOLDING  = 8'h03;
    localparam logic [7:0]  FN_WRITE_MULTIPLE = 8'h10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    t_wire_byte  frame_bytes_q[$];

    logic [7:0]  server_addr;
    logic        crc_low_first;
    logic [15:0] write_crc;
    logic        write_open;
    int          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                      input logic [7:0] b);
        crc = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC16_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log short if the design is badly broken
        if (fail_cnt < 50) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        fail_cnt++;
    endtask

    task automatic emit_byte(input logic [7:0] b, inout logic [15:0] crc);
        frame_bytes_q.push_back('{data: b, last: 1'b0});
        crc = crc16_modbus_next(crc, b);
    endtask

    task automatic emit_crc(input logic [15:0] crc);
        logic [7:0] first_out;
        logic [7:0] second_out;
        first_out  = crc_low_first ? crc[7:0] : crc[15:8];
        second_out = crc_low_first ? crc[15:8] : crc[7:0];
        frame_bytes_q.push_back('{data: first_out, last: 1'b0});
        frame_bytes_q.push_back('{data: second_out, last: 1'b1});
    endtask

    task automatic predict_request_bytes(input logic cmd, input logic [15:0] sa,
                                         input logic [6:0] cnt, input logic [15:0] val,
                                         input logic first, input logic last);
        logic [15:0] crc;
        if (cmd == CMD_READ) begin
            // a read always closes any write frame that was left open
            write_crc  = CRC16_INIT;
            write_open = 1'b0;
            crc = CRC16_INIT;
            emit_byte(server_addr, crc);
            emit_byte(FN_READ_HOLDING, crc);
            emit_byte(sa[15:8], crc);
            emit_byte(sa[7:0], crc);
            emit_byte(8'h00, crc);
            emit_byte({1'b0, cnt}, crc);
            emit_crc(crc);
        end else if (first || write_open) begin
            crc = first ? CRC16_INIT : write_crc;
            if (first) begin
                emit_byte(server_addr, crc);
                emit_byte(FN_WRITE_MULTIPLE, crc);
                emit_byte(sa[15:8], crc);
                emit_byte(sa[7:0], crc);
                emit_byte(8'h00, crc);
                emit_byte({1'b0, cnt}, crc);
                emit_byte({cnt, 1'b0}, crc);
            end
            emit_byte(val[15:8], crc);
            emit_byte(val[7:0], crc);
            if (last) begin
                emit_crc(crc);
                write_crc  = CRC16_INIT;
                write_open = 1'b0;
            end else begin
                write_crc  = crc;
                write_open = 1'b1;
            end
        end
        // word with no open frame and no first flag: dropped silently
    endtask

    task automatic check_frame_byte();
        t_wire_byte want;
        if (frame_bytes_q.size() == 0) begin
            report_mismatch($sformatf("byte %02h popped with nothing expected",
                                      i_frame_byte));
        end else begin
            want = frame_bytes_q.pop_front();
            if (i_frame_byte !== want.data) begin
                report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                          i_frame_byte, want.data));
            end
            if (i_last_byte !== want.last) begin
                report_mismatch($sformatf("last_byte %b, expected %b on byte %02h",
                                          i_last_byte, want.last, want.data));
            end
        end
    endtask

    // results are checked before new predictions so ordering within the edge is fixed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            server_addr   = 8'd1;
            crc_low_first = 1'b0;
            write_crc     = CRC16_INIT;
            write_open    = 1'b0;
            frame_bytes_q.delete();
        end else begin
            if (pop && !empty) begin
                check_frame_byte();
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SERVER_ADDR) begin
                    server_addr = i_cfg_data;
                end else begin
                    crc_low_first = i_cfg_data[0];
                end
            end
            if (push && !full) begin
                predict_request_bytes(i_cmd, i_start_address, i_word_count, i_word_value,
                                      i_first_word, i_last_word);
            end
        end
        o_pending <= frame_bytes_q.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mrrf_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_cmd;
    logic [15:0] i_start_address;
    logic [6:0]  i_word_count;
    logic [15:0] i_word_value;
    logic        i_first_word;
    logic        i_last_word;
    logic        empty;
    logic        pop;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          pending;

    // no_idle: both sides run back to back; hold_req: receiver stalls for a long stretch
    logic        no_idle = 1'b0;
    logic        hold_req = 1'b0;

    modbus_rtu_request_framer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_start_address (i_start_address),
        .i_word_count    (i_word_count),
        .i_word_value    (i_word_value),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .empty           (empty),
        .pop             (pop),
        .o_frame_byte    (o_frame_byte),
        .o_last_byte     (o_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    modbus_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_start_address (i_start_address),
        .i_word_count    (i_word_count),
        .i_word_value    (i_word_value),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .empty           (empty),
        .pop             (pop),
        .i_frame_byte    (o_frame_byte),
        .i_last_byte     (o_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // offer one request item and hold it until the block takes it
    task automatic offer_request(input logic cmd, input logic [15:0] sa,
                                 input logic [6:0] cnt, input logic [15:0] val,
                                 input logic first, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push            = 1'b1;
        i_cmd           = cmd;
        i_start_address = sa;
        i_word_count    = cnt;
        i_word_value    = val;
        i_first_word    = first;
        i_last_word     = last;
        do @(posedge i_clk); while (full);
    endtask

    // stop sending, wait for every expected byte, then let an ignored word drain
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic send_random_traffic(input int n_items);
        int          sent;
        int          kind;
        int          nwords;
        logic [6:0]  cnt;
        logic        drop_last;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                offer_request(CMD_READ, 16'($urandom), 7'($urandom), 16'($urandom),
                              1'($urandom), 1'($urandom));
                sent++;
            end else if (kind < 88) begin
                nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(1, 4);
                // count field usually matches, sometimes anything the 7 bits hold
                cnt = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(nwords);
                drop_last = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < nwords; k++) begin
                    offer_request(CMD_WRITE, 16'($urandom), (k == 0) ? cnt : 7'($urandom),
                                  16'($urandom), k == 0, (k == nwords - 1) && !drop_last);
                    sent++;
                end
            end else begin
                // stray word: ignored unless a truncated frame is still open
                offer_request(CMD_WRITE, 16'($urandom), 7'($urandom), 16'($urandom), 1'b0,
                              1'($urandom));
            end
        end
    endtask

    // receiver
    initial begin
        int hold;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold = 400;
                hold_req = 1'b0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 17);
            end
            repeat (hold) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        #10_000_000;
        $display("modbus_rtu_request_framer_top test failed");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_cmd           = CMD_READ;
        i_start_address = '0;
        i_word_count    = '0;
        i_word_value    = '0;
        i_first_word    = 1'b0;
        i_last_word     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_SERVER_ADDR;
        i_cfg_data      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset configuration
        offer_request(CMD_READ,  16'h0000, 7'd0,   16'h0000, 1'b1, 1'b1);
        offer_request(CMD_READ,  16'hFFFF, 7'd127, 16'hFFFF, 1'b0, 1'b0);
        offer_request(CMD_READ,  16'h80FF, 7'd125, 16'h8080, 1'b0, 1'b1);
        // stray words with no frame open, then a single-word frame and a three-word frame
        offer_request(CMD_WRITE, 16'hFFFF, 7'd127, 16'hFFFF, 1'b0, 1'b1);
        offer_request(CMD_WRITE, 16'h1234, 7'd5,   16'h5678, 1'b0, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd1,   16'hFFFF, 1'b1, 1'b1);
        offer_request(CMD_WRITE, 16'h8000, 7'd3,   16'h0000, 1'b1, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd0,   16'h8001, 1'b0, 1'b0);
        offer_request(CMD_WRITE, 16'hFFFF, 7'd127, 16'h7FFE, 1'b0, 1'b1);
        // read cuts an open write frame, the next stray word is dropped
        offer_request(CMD_WRITE, 16'h0102, 7'd2,   16'hABCD, 1'b1, 1'b0);
        offer_request(CMD_READ,  16'h0010, 7'd1,   16'h0000, 1'b0, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd0,   16'h1234, 1'b0, 1'b1);
        // restart of an open frame, then single-word frames and a two-word frame
        offer_request(CMD_WRITE, 16'hFFFF, 7'd4,   16'h00FF, 1'b1, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd1,   16'hFF00, 1'b1, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd0,   16'hFFFF, 1'b0, 1'b1);
        offer_request(CMD_WRITE, 16'h7FFF, 7'd126, 16'h8080, 1'b1, 1'b1);
        offer_request(CMD_WRITE, 16'hFFFF, 7'd0,   16'h0000, 1'b1, 1'b1);
        offer_request(CMD_WRITE, 16'h0001, 7'd127, 16'hFFFF, 1'b1, 1'b0);
        offer_request(CMD_WRITE, 16'h0000, 7'd0,   16'h0000, 1'b0, 1'b1);
        settle();

        // lowest address, crc low byte first; receiver stalls long so the input backs up
        write_reg(REG_SERVER_ADDR, 8'd0);
        write_reg(REG_CRC_ORDER, 8'd1);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        send_random_traffic(75);
        settle();

        no_idle = 1'b0;
        write_reg(REG_SERVER_ADDR, 8'd247);
        write_reg(REG_CRC_ORDER, 8'd0);
        send_random_traffic(75);
        settle();

        for (int p = 0; p < 4; p++) begin
            write_reg(REG_SERVER_ADDR, 8'($urandom_range(0, 247)));
            write_reg(REG_CRC_ORDER, 8'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                // sender pauses mid-phase until the output side has caught up
                send_random_traffic(40);
                settle();
                send_random_traffic(35);
            end else begin
                send_random_traffic(75);
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("modbus_rtu_request_framer_top test passed");
        end else begin
            $display("modbus_rtu_request_framer_top test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mrrf_pkg.sv
rtl/mrrf_front.sv
rtl/mrrf_queue.sv
rtl/mrrf_back.sv
rtl/modbus_rtu_request_framer_top.sv
sim/modbus_frame_checker.sv
sim/tb.sv
